>>> rtl/core/timed_mission_motion_sequencer_unit_assert.svh
// ----------------------------------------------------------------------------
// timed mission motion sequencer assertion macros
// shared property wrappers for the sequencer's concurrent checks
// ----------------------------------------------------------------------------
`ifndef TIMED_MISSION_MOTION_SEQUENCER_UNIT_ASSERT_SVH
`define TIMED_MISSION_MOTION_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TMMS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tmms check failed");

// next-cycle implication, checked outside reset
`define TMMS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tmms check failed");

`endif

>>> rtl/core/tmms_pkg.sv
// ----------------------------------------------------------------------------
// tmms_pkg
// types and constants shared by the timed mission motion sequencer
// ----------------------------------------------------------------------------
package tmms_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_FORWARD = 3'd1,
        PH_PIVOT   = 3'd2,
        PH_FINAL   = 3'd3,
        PH_SWEEP   = 3'd4,
        PH_HALT    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        CFG_FORWARD_PULSES = 3'd0,
        CFG_PIVOT_PULSES   = 3'd1,
        CFG_FINAL_PULSES   = 3'd2,
        CFG_START_DELAY    = 3'd3,
        CFG_END_TIME       = 3'd4,
        CFG_OBSTACLE_THR   = 3'd5
    } cfg_index_t;

    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
    localparam logic [19:0] ELAPSED_MAX = 20'hFFFFF;

    localparam logic [7:0] PWM_STOP         = 8'd255;
    localparam logic [7:0] PWM_LEG_R_BLUE   = 8'd195;
    localparam logic [7:0] PWM_LEG_R_YELLOW = 8'd197;
    localparam logic [7:0] PWM_LEG_L        = 8'd190;
    localparam logic [7:0] PWM_PIVOT_FAST   = 8'd230;
    localparam logic [7:0] PWM_PIVOT_SLOW   = 8'd150;

    localparam logic [7:0] SERVO_TOP  = 8'd180;
    localparam logic [7:0] SERVO_STEP = 8'd10;

    localparam logic [15:0] RST_FORWARD_PULSES = 16'd8000;
    localparam logic [15:0] RST_PIVOT_PULSES   = 16'd750;
    localparam logic [15:0] RST_FINAL_PULSES   = 16'd650;
    localparam logic [19:0] RST_START_DELAY    = 20'd850;
    localparam logic [19:0] RST_END_TIME       = 20'd1000;
    localparam logic [7:0]  RST_OBSTACLE_THR   = 8'd100;

    typedef struct packed {
        logic [15:0] forward_pulses;
        logic [15:0] pivot_pulses;
        logic [15:0] final_pulses;
        logic [19:0] start_delay_periods;
        logic [19:0] end_time_periods;
        logic [7:0]  obstacle_threshold;
    } cfg_t;

    typedef struct packed {
        logic       start_active;
        logic       team_blue;
        logic [9:0] pulses_right;
        logic [9:0] pulses_left;
        logic [7:0] range_left;
        logic [7:0] range_middle;
        logic [7:0] range_right;
        logic [2:0] range_valid;
    } item_t;

    typedef struct packed {
        phase_t      phase;
        logic        clock_running;
        logic [19:0] elapsed_periods;
        logic [15:0] count_right;
        logic [15:0] count_left;
        logic [7:0]  servo_position;
        logic        sweep_rising;
    } state_t;

    typedef struct packed {
        logic [7:0] pwm_right;
        logic [7:0] pwm_left;
        logic [7:0] servo_angle;
        logic [2:0] mission_phase;
        logic       obstacle_seen;
    } result_t;

endpackage

>>> rtl/core/timed_mission_motion_sequencer_unit.sv
// ----------------------------------------------------------------------------
// timed_mission_motion_sequencer_unit
// mission sequencer: one sensor/encoder request in, one motor/servo request out
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one request per control period (start cord, team, encoder pulses,
//   three ranges and their valid flags). m_ channel: one result per request (two
//   motor pwm levels, servo angle, mission phase, obstacle flag). cfg channel:
//   register writes by index, always ready; the user must write only while idle,
//   which the block does not enforce. flow and throughput:
//   a request accepted into the input register waits there until the result
//   slot is free; then the mission step runs and loads the result register,
//   which drives m_tvalid. one request per cycle is sustained while m_tready
//   is high; the limit is the single step between input and result registers.
// reset
//   aresetn low at an edge empties both registers, loads the register reset
//   values, sets phase idle, stops the period clock, clears pulse counts and
//   servo position and points the sweep upward.
// stalls
//   while m_tready is low the result holds; one more request is still taken
//   into the input register, then s_tready drops until the result drains.
// ----------------------------------------------------------------------------
`include "timed_mission_motion_sequencer_unit_assert.svh"

module timed_mission_motion_sequencer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // sensor/encoder requests
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] start_active, [1] team_blue, [11:2] pulses_right, [21:12] pulses_left,
    // [29:22] range_left, [37:30] range_middle, [45:38] range_right,
    // [48:46] range_valid, [55:49] zero
    input  logic [55:0] s_tdata,
    // motor/servo results
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] pwm_right, [15:8] pwm_left, [23:16] servo_angle,
    // [26:24] mission_phase, [27] obstacle_seen, [31:28] zero
    output logic [31:0] m_tdata,
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    // configuration registers
    tmms_pkg::cfg_t    cfg_reg;
    tmms_pkg::cfg_t    cfg_next;

    // input register
    logic              in_valid_reg;
    logic              in_valid_next;
    tmms_pkg::item_t   item_reg;
    tmms_pkg::item_t   item_in;

    // mission state
    tmms_pkg::state_t  state_reg;
    tmms_pkg::state_t  state_step;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    tmms_pkg::result_t result_reg;
    tmms_pkg::result_t result_step;

    logic              s_accept;
    logic              advance;
    tmms_pkg::state_t  state_rst;

    assign cfg_ready = 1'b1;

    // step runs when the input register holds a request and the result slot frees
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign item_in.start_active = s_tdata[0];
    assign item_in.team_blue    = s_tdata[1];
    assign item_in.pulses_right = s_tdata[11:2];
    assign item_in.pulses_left  = s_tdata[21:12];
    assign item_in.range_left   = s_tdata[29:22];
    assign item_in.range_middle = s_tdata[37:30];
    assign item_in.range_right  = s_tdata[45:38];
    assign item_in.range_valid  = s_tdata[48:46];

    assign state_rst.phase           = tmms_pkg::PH_IDLE;
    assign state_rst.clock_running   = 1'b0;
    assign state_rst.elapsed_periods = '0;
    assign state_rst.count_right     = '0;
    assign state_rst.count_left      = '0;
    assign state_rst.servo_position  = '0;
    assign state_rst.sweep_rising    = 1'b1;

    // register file writes, unknown indexes ignored
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (tmms_pkg::cfg_index_t'(cfg_index))
                tmms_pkg::CFG_FORWARD_PULSES: cfg_next.forward_pulses      = cfg_data[15:0];
                tmms_pkg::CFG_PIVOT_PULSES:   cfg_next.pivot_pulses        = cfg_data[15:0];
                tmms_pkg::CFG_FINAL_PULSES:   cfg_next.final_pulses        = cfg_data[15:0];
                tmms_pkg::CFG_START_DELAY:    cfg_next.start_delay_periods = cfg_data;
                tmms_pkg::CFG_END_TIME:       cfg_next.end_time_periods    = cfg_data;
                tmms_pkg::CFG_OBSTACLE_THR:   cfg_next.obstacle_threshold  = cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    tmms_step u_step (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_step),
        .res  (result_step)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.forward_pulses      <= tmms_pkg::RST_FORWARD_PULSES;
            cfg_reg.pivot_pulses        <= tmms_pkg::RST_PIVOT_PULSES;
            cfg_reg.final_pulses        <= tmms_pkg::RST_FINAL_PULSES;
            cfg_reg.start_delay_periods <= tmms_pkg::RST_START_DELAY;
            cfg_reg.end_time_periods    <= tmms_pkg::RST_END_TIME;
            cfg_reg.obstacle_threshold  <= tmms_pkg::RST_OBSTACLE_THR;
            in_valid_reg                <= 1'b0;
            out_valid_reg               <= 1'b0;
            state_reg                   <= state_rst;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_step;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= item_in;
        end
        if (advance) begin
            result_reg <= result_step;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       result_reg.obstacle_seen,
                       result_reg.mission_phase,
                       result_reg.servo_angle,
                       result_reg.pwm_left,
                       result_reg.pwm_right};

    // leaving idle needs the period clock to have started
    `TMMS_ASSERT_SAME(a_phase_needs_clock, aclk, aresetn,
        state_reg.phase != tmms_pkg::PH_IDLE, state_reg.clock_running)
    // the period count stays at zero until the clock starts
    `TMMS_ASSERT_SAME(a_elapsed_held, aclk, aresetn,
        !state_reg.clock_running, state_reg.elapsed_periods == 20'd0)
    // the servo never leaves its range
    `TMMS_ASSERT_SAME(a_servo_range, aclk, aresetn,
        1'b1, state_reg.servo_position <= tmms_pkg::SERVO_TOP)
    // motors are stopped in every sweep result
    `TMMS_ASSERT_NEXT(a_sweep_stops, aclk, aresetn,
        advance && (result_step.mission_phase == tmms_pkg::PH_SWEEP),
        (result_reg.pwm_right == tmms_pkg::PWM_STOP) &&
        (result_reg.pwm_left == tmms_pkg::PWM_STOP))

endmodule

>>> rtl/core/tmms_step.sv
// ----------------------------------------------------------------------------
// tmms_step
// one control period of the mission: next state and motor/servo commands
// ----------------------------------------------------------------------------
module tmms_step (
    input  tmms_pkg::cfg_t    cfg,
    input  tmms_pkg::state_t  cur,
    input  tmms_pkg::item_t   item,
    output tmms_pkg::state_t  nxt,
    output tmms_pkg::result_t res
);

    logic               obstacle;
    logic [16:0]        sum_r;
    logic [16:0]        sum_l;
    logic [15:0]        cnt_r;
    logic [15:0]        cnt_l;
    logic [19:0]        elapsed;
    logic               running;
    tmms_pkg::phase_t   ph;
    logic [15:0]        goal;
    logic [7:0]         pwm_r;
    logic [7:0]         pwm_l;
    logic [7:0]         servo;
    logic               rising;
    logic [7:0]         servo_up;

    assign obstacle = (item.range_valid[0] && (item.range_left   <= cfg.obstacle_threshold)) ||
                      (item.range_valid[1] && (item.range_middle <= cfg.obstacle_threshold)) ||
                      (item.range_valid[2] && (item.range_right  <= cfg.obstacle_threshold));

    // saturating pulse accumulation, done every period
    assign sum_r = {1'b0, cur.count_right} + {7'd0, item.pulses_right};
    assign sum_l = {1'b0, cur.count_left}  + {7'd0, item.pulses_left};

    assign servo_up = cur.servo_position + tmms_pkg::SERVO_STEP;

    always_comb begin
        cnt_r   = sum_r[16] ? tmms_pkg::COUNT_MAX : sum_r[15:0];
        cnt_l   = sum_l[16] ? tmms_pkg::COUNT_MAX : sum_l[15:0];
        running = cur.clock_running;
        elapsed = cur.elapsed_periods;
        ph      = cur.phase;
        pwm_r   = tmms_pkg::PWM_STOP;
        pwm_l   = tmms_pkg::PWM_STOP;
        servo   = cur.servo_position;
        rising  = cur.sweep_rising;
        goal    = cfg.forward_pulses;

        // period clock starts on the first started period
        if (cur.clock_running) begin
            if (cur.elapsed_periods != tmms_pkg::ELAPSED_MAX) begin
                elapsed = cur.elapsed_periods + 20'd1;
            end
        end else if (item.start_active) begin
            running = 1'b1;
            elapsed = '0;
        end

        if (item.start_active) begin
            if ((ph == tmms_pkg::PH_IDLE) && (elapsed >= cfg.start_delay_periods)) begin
                ph = tmms_pkg::PH_FORWARD;
            end
            if (elapsed >= cfg.end_time_periods) begin
                ph = tmms_pkg::PH_SWEEP;
            end

            case (ph)
                tmms_pkg::PH_IDLE: begin
                    cnt_r = '0;
                    cnt_l = '0;
                end
                tmms_pkg::PH_FORWARD, tmms_pkg::PH_FINAL: begin
                    goal = (ph == tmms_pkg::PH_FORWARD) ? cfg.forward_pulses
                                                        : cfg.final_pulses;
                    if (!obstacle) begin
                        pwm_r = item.team_blue ? tmms_pkg::PWM_LEG_R_BLUE
                                               : tmms_pkg::PWM_LEG_R_YELLOW;
                        pwm_l = tmms_pkg::PWM_LEG_L;
                        if ((cnt_r >= goal) && (cnt_l >= goal)) begin
                            ph    = (ph == tmms_pkg::PH_FORWARD) ? tmms_pkg::PH_PIVOT
                                                                 : tmms_pkg::PH_HALT;
                            cnt_r = '0;
                            cnt_l = '0;
                        end
                    end
                end
                tmms_pkg::PH_PIVOT: begin
                    if (!obstacle) begin
                        pwm_r = item.team_blue ? tmms_pkg::PWM_PIVOT_SLOW
                                               : tmms_pkg::PWM_PIVOT_FAST;
                        pwm_l = item.team_blue ? tmms_pkg::PWM_PIVOT_FAST
                                               : tmms_pkg::PWM_PIVOT_SLOW;
                        if ((item.team_blue ? cnt_r : cnt_l) >= cfg.pivot_pulses) begin
                            ph    = tmms_pkg::PH_FINAL;
                            cnt_r = '0;
                            cnt_l = '0;
                        end
                    end
                end
                tmms_pkg::PH_SWEEP: begin
                    if (cur.sweep_rising) begin
                        if (servo_up >= tmms_pkg::SERVO_TOP) begin
                            servo  = tmms_pkg::SERVO_TOP;
                            rising = 1'b0;
                        end else begin
                            servo = servo_up;
                        end
                    end else if (cur.servo_position <= tmms_pkg::SERVO_STEP) begin
                        servo  = '0;
                        rising = 1'b1;
                    end else begin
                        servo = cur.servo_position - tmms_pkg::SERVO_STEP;
                    end
                end
                default: begin
                end
            endcase
        end

        nxt.phase           = ph;
        nxt.clock_running   = running;
        nxt.elapsed_periods = elapsed;
        nxt.count_right     = cnt_r;
        nxt.count_left      = cnt_l;
        nxt.servo_position  = servo;
        nxt.sweep_rising    = rising;

        res.pwm_right     = pwm_r;
        res.pwm_left      = pwm_l;
        res.servo_angle   = servo;
        res.mission_phase = ph;
        res.obstacle_seen = obstacle;
    end

endmodule

>>> tb/motion_sequencer_checker.sv
// ----------------------------------------------------------------------------
// motion sequencer checker
// watches the request, result and register channels of the mission
// sequencer, predicts each result from its own copy of the mission state and
// compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module motion_sequencer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data,
    output int unsigned mismatch_count,
    output int unsigned moves_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    tmms_pkg::cfg_t    settings;
    tmms_pkg::state_t  mission;
    tmms_pkg::result_t expected_moves [$];
    tmms_pkg::result_t want;
    tmms_pkg::result_t got;

    function automatic tmms_pkg::item_t unpack_request(logic [55:0] d);
        tmms_pkg::item_t rq;
        rq.start_active = d[0];
        rq.team_blue    = d[1];
        rq.pulses_right = d[11:2];
        rq.pulses_left  = d[21:12];
        rq.range_left   = d[29:22];
        rq.range_middle = d[37:30];
        rq.range_right  = d[45:38];
        rq.range_valid  = d[48:46];
        return rq;
    endfunction

    function automatic void clear_counts();
        mission.count_right = '0;
        mission.count_left  = '0;
    endfunction

    // one control period of the mission
    function automatic tmms_pkg::result_t advance_mission(tmms_pkg::item_t rq);
        tmms_pkg::result_t r;
        logic              blocked;
        logic [16:0]       sum_r;
        logic [16:0]       sum_l;
        logic [15:0]       goal;
        logic [15:0]       watched;

        r.pwm_right = tmms_pkg::PWM_STOP;
        r.pwm_left  = tmms_pkg::PWM_STOP;
        blocked = (rq.range_valid[0] && rq.range_left   <= settings.obstacle_threshold) ||
                  (rq.range_valid[1] && rq.range_middle <= settings.obstacle_threshold) ||
                  (rq.range_valid[2] && rq.range_right  <= settings.obstacle_threshold);

        sum_r = {1'b0, mission.count_right} + 17'(rq.pulses_right);
        sum_l = {1'b0, mission.count_left} + 17'(rq.pulses_left);
        mission.count_right = sum_r[16] ? tmms_pkg::COUNT_MAX : sum_r[15:0];
        mission.count_left  = sum_l[16] ? tmms_pkg::COUNT_MAX : sum_l[15:0];

        if (mission.clock_running) begin
            if (mission.elapsed_periods != tmms_pkg::ELAPSED_MAX)
                mission.elapsed_periods = mission.elapsed_periods + 20'd1;
        end else if (rq.start_active) begin
            mission.clock_running   = 1'b1;
            mission.elapsed_periods = '0;
        end

        if (rq.start_active) begin
            if (mission.phase == tmms_pkg::PH_IDLE &&
                mission.elapsed_periods >= settings.start_delay_periods)
                mission.phase = tmms_pkg::PH_FORWARD;
            if (mission.elapsed_periods >= settings.end_time_periods)
                mission.phase = tmms_pkg::PH_SWEEP;

            case (mission.phase)
                tmms_pkg::PH_IDLE: begin
                    clear_counts();
                end
                tmms_pkg::PH_FORWARD, tmms_pkg::PH_FINAL: begin
                    if (!blocked) begin
                        r.pwm_right = rq.team_blue ? tmms_pkg::PWM_LEG_R_BLUE
                                                   : tmms_pkg::PWM_LEG_R_YELLOW;
                        r.pwm_left  = tmms_pkg::PWM_LEG_L;
                        goal = (mission.phase == tmms_pkg::PH_FORWARD)
                               ? settings.forward_pulses : settings.final_pulses;
                        if (mission.count_right >= goal && mission.count_left >= goal) begin
                            if (mission.phase == tmms_pkg::PH_FORWARD)
                                mission.phase = tmms_pkg::PH_PIVOT;
                            else
                                mission.phase = tmms_pkg::PH_HALT;
                            clear_counts();
                        end
                    end
                end
                tmms_pkg::PH_PIVOT: begin
                    if (!blocked) begin
                        r.pwm_right = rq.team_blue ? tmms_pkg::PWM_PIVOT_SLOW
                                                   : tmms_pkg::PWM_PIVOT_FAST;
                        r.pwm_left  = rq.team_blue ? tmms_pkg::PWM_PIVOT_FAST
                                                   : tmms_pkg::PWM_PIVOT_SLOW;
                        watched = rq.team_blue ? mission.count_right : mission.count_left;
                        if (watched >= settings.pivot_pulses) begin
                            mission.phase = tmms_pkg::PH_FINAL;
                            clear_counts();
                        end
                    end
                end
                tmms_pkg::PH_SWEEP: begin
                    if (mission.sweep_rising) begin
                        mission.servo_position = mission.servo_position + tmms_pkg::SERVO_STEP;
                        if (mission.servo_position >= tmms_pkg::SERVO_TOP) begin
                            mission.servo_position = tmms_pkg::SERVO_TOP;
                            mission.sweep_rising   = 1'b0;
                        end
                    end else if (mission.servo_position <= tmms_pkg::SERVO_STEP) begin
                        mission.servo_position = '0;
                        mission.sweep_rising   = 1'b1;
                    end else begin
                        mission.servo_position = mission.servo_position - tmms_pkg::SERVO_STEP;
                    end
                end
                default: ;
            endcase
        end

        r.servo_angle   = mission.servo_position;
        r.mission_phase = mission.phase;
        r.obstacle_seen = blocked;
        return r;
    endfunction

    function automatic void flag_field(string what, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            if (mismatch_count < 10)
                $display("mismatch in %s: expected %0d, got %0d", what, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            settings.forward_pulses      = tmms_pkg::RST_FORWARD_PULSES;
            settings.pivot_pulses        = tmms_pkg::RST_PIVOT_PULSES;
            settings.final_pulses        = tmms_pkg::RST_FINAL_PULSES;
            settings.start_delay_periods = tmms_pkg::RST_START_DELAY;
            settings.end_time_periods    = tmms_pkg::RST_END_TIME;
            settings.obstacle_threshold  = tmms_pkg::RST_OBSTACLE_THR;
            mission.phase           = tmms_pkg::PH_IDLE;
            mission.clock_running   = 1'b0;
            mission.elapsed_periods = '0;
            mission.count_right     = '0;
            mission.count_left      = '0;
            mission.servo_position  = '0;
            mission.sweep_rising    = 1'b1;
            expected_moves.delete();
        end else begin
            // results first: a request taken at this edge cannot be answered yet
            if (m_tvalid && m_tready) begin
                got.pwm_right     = m_tdata[7:0];
                got.pwm_left      = m_tdata[15:8];
                got.servo_angle   = m_tdata[23:16];
                got.mission_phase = m_tdata[26:24];
                got.obstacle_seen = m_tdata[27];
                if (expected_moves.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("result %h with nothing expected", m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_moves.pop_front();
                    flag_field("pwm_right", want.pwm_right, got.pwm_right);
                    flag_field("pwm_left", want.pwm_left, got.pwm_left);
                    flag_field("servo_angle", want.servo_angle, got.servo_angle);
                    flag_field("mission_phase", want.mission_phase, got.mission_phase);
                    flag_field("obstacle_seen", want.obstacle_seen, got.obstacle_seen);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tmms_pkg::CFG_FORWARD_PULSES:
                        settings.forward_pulses = cfg_data[15:0];
                    tmms_pkg::CFG_PIVOT_PULSES:
                        settings.pivot_pulses = cfg_data[15:0];
                    tmms_pkg::CFG_FINAL_PULSES:
                        settings.final_pulses = cfg_data[15:0];
                    tmms_pkg::CFG_START_DELAY:
                        settings.start_delay_periods = cfg_data;
                    tmms_pkg::CFG_END_TIME:
                        settings.end_time_periods = cfg_data;
                    tmms_pkg::CFG_OBSTACLE_THR:
                        settings.obstacle_threshold = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_moves.push_back(advance_mission(unpack_request(s_tdata)));
        end
        moves_pending <= expected_moves.size();
    end

endmodule

>>> tb/timed_mission_motion_sequencer_unit_test.sv
// ----------------------------------------------------------------------------
// timed mission motion sequencer testbench
// drives sensor requests and register writes into the sequencer, stalls the
// result side at random and hands all checking to the sequencer checker;
// runs a full mission from idle through the legs to halt and the servo sweep
// ----------------------------------------------------------------------------
module timed_mission_motion_sequencer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [0] start_active, [1] team_blue, [11:2] pulses_right, [21:12] pulses_left,
    // [29:22] range_left, [37:30] range_middle, [45:38] range_right,
    // [48:46] range_valid, [55:49] zero
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [7:0] pwm_right, [15:8] pwm_left, [23:16] servo_angle,
    // [26:24] mission_phase, [27] obstacle_seen, [31:28] zero
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [19:0] cfg_data;

    int unsigned mismatch_count;
    int unsigned moves_pending;

    // request count and our own view of the period clock, for timing the phases
    int unsigned requests_sent = 0;
    logic        clock_on = 1'b0;
    int unsigned periods_since_start = 0;
    int unsigned cycle_count = 0;

    timed_mission_motion_sequencer_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    motion_sequencer_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .moves_pending  (moves_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [55:0] pack_request(tmms_pkg::item_t rq);
        return {7'd0, rq.range_valid, rq.range_right, rq.range_middle, rq.range_left,
                rq.pulses_left, rq.pulses_right, rq.team_blue, rq.start_active};
    endfunction

    // mostly far readings, now and then one at or inside the threshold
    function automatic logic [7:0] pick_range(logic [7:0] thr);
        if ($urandom_range(99, 0) < 5)
            return 8'($urandom_range(thr, 0));
        return 8'($urandom_range(255, thr));
    endfunction

    // one control period: small pulse counts usually, a full-scale burst rarely
    function automatic tmms_pkg::item_t random_request(logic started, int unsigned pulse_cap,
                                                       logic [7:0] thr);
        tmms_pkg::item_t rq;
        rq.start_active = started;
        rq.team_blue    = 1'($urandom_range(1, 0));
        rq.pulses_right = ($urandom_range(99, 0) < 6) ? 10'($urandom_range(1023, 0))
                                                       : 10'($urandom_range(pulse_cap, 0));
        rq.pulses_left  = ($urandom_range(99, 0) < 6) ? 10'($urandom_range(1023, 0))
                                                       : 10'($urandom_range(pulse_cap, 0));
        rq.range_left   = pick_range(thr);
        rq.range_middle = pick_range(thr);
        rq.range_right  = pick_range(thr);
        rq.range_valid  = 3'($urandom_range(7, 0));
        return rq;
    endfunction

    // offer one request, with random gaps except in the back-to-back window
    task automatic send_request(input tmms_pkg::item_t rq);
        while (!(requests_sent >= 450 && requests_sent < 600) &&
               $urandom_range(99, 0) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_request(rq);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
        // mirror the block's period clock so register values can be placed ahead
        if (clock_on)
            periods_since_start++;
        else if (rq.start_active)
            clock_on = 1'b1;
    endtask

    // leaves cfg_valid high so back-to-back writes never toggle it within a step
    task automatic write_reg(input tmms_pkg::cfg_index_t idx, input logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic load_settings(input logic [15:0] fwd, input logic [15:0] pvt,
                                 input logic [15:0] fin, input logic [19:0] dly,
                                 input logic [19:0] stop_at, input logic [7:0] thr);
        write_reg(tmms_pkg::CFG_FORWARD_PULSES, 20'(fwd));
        write_reg(tmms_pkg::CFG_PIVOT_PULSES, 20'(pvt));
        write_reg(tmms_pkg::CFG_FINAL_PULSES, 20'(fin));
        write_reg(tmms_pkg::CFG_START_DELAY, dly);
        write_reg(tmms_pkg::CFG_END_TIME, stop_at);
        write_reg(tmms_pkg::CFG_OBSTACLE_THR, 20'(thr));
        cfg_valid <= 1'b0;
    endtask

    // every request yields one result, so an empty scoreboard means the block is idle
    task automatic wait_for_results();
        do @(posedge aclk); while (moves_pending != 0);
    endtask

    // result side: random stalls, one long hold-off to back the block up,
    // and a stretch with no stalls at all
    initial begin
        int unsigned hold_left;
        logic        held_once;
        hold_left = 0;
        held_once = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!held_once && requests_sent >= 300) begin
                held_once = 1'b1;
                hold_left = 120;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (requests_sent >= 600 && requests_sent < 750) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99, 0) >= 23);
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL timed_mission_motion_sequencer_unit");
        $finish;
    end

    initial begin
        tmms_pkg::item_t rq;
        logic [19:0]     base;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= tmms_pkg::CFG_FORWARD_PULSES;
        cfg_data  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes: goals out of reach, start delay and end time at maximum,
        // threshold zero so only a zero reading counts as an obstacle
        load_settings(16'hFFFF, 16'd0, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 8'd0);

        // not started: all fields low, then all high
        rq = '0;
        send_request(rq);
        rq = '1;
        rq.start_active = 1'b0;
        send_request(rq);
        // zero readings with one valid flag at a time, then none valid
        for (int i = 0; i < 4; i++) begin
            rq = '0;
            rq.range_valid = (i == 3) ? 3'd0 : 3'(1 << i);
            send_request(rq);
        end
        // just above the threshold on every sensor
        rq = '0;
        rq.range_left   = 8'd1;
        rq.range_middle = 8'd1;
        rq.range_right  = 8'd1;
        rq.range_valid  = 3'd7;
        send_request(rq);

        // heavy pulses before the start drive both counts into saturation
        for (int i = 0; i < 70; i++) begin
            rq = random_request(1'b0, 1023, 8'd0);
            rq.pulses_right = 10'($urandom_range(1023, 900));
            rq.pulses_left  = 10'($urandom_range(1023, 900));
            send_request(rq);
        end

        // first start: clock begins, still idle behind the long delay, counts clear
        rq = '0;
        rq.start_active = 1'b1;
        send_request(rq);
        for (int i = 0; i < 10; i++)
            send_request(random_request(i % 4 != 3, 63, 8'd0));
        s_tvalid <= 1'b0;
        wait_for_results();

        // full mission: short idle wait, then forward, pivot, final leg, halt
        base = 20'(periods_since_start);
        load_settings(16'd1500, 16'd500, 16'd900, base + 20'd20, base + 20'd450, 8'd60);
        for (int i = 0; i < 400; i++) begin
            if ($urandom_range(99, 0) < 12)
                send_request(random_request(1'b0, 1023, 8'd60));
            else
                send_request(random_request(1'b1, 63, 8'd60));
        end
        s_tvalid <= 1'b0;
        wait_for_results();

        // end time zero forces the sweep out of the halted phase; threshold at
        // the top makes every valid reading an obstacle
        load_settings(16'd0, 16'hFFFF, 16'd0, 20'd0, 20'd0, 8'd255);
        for (int i = 0; i < 400; i++)
            send_request(random_request($urandom_range(99, 0) >= 10, 1023, 8'd255));
        s_tvalid <= 1'b0;
        wait_for_results();
        repeat (4) @(posedge aclk);

        if (mismatch_count == 0 && moves_pending == 0)
            $display("PASS timed_mission_motion_sequencer_unit");
        else
            $display("FAIL timed_mission_motion_sequencer_unit");
        $finish;
    end

endmodule
